// ===== hw/rtl/dmrfp_pkg.sv =====
// ----------------------------------------------------------------------------
// dmrfp_pkg
// shared constants and the crc-16 byte step for the dual motor reply parser
// ----------------------------------------------------------------------------
package dmrfp_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned SPEED_W    = 16;
  localparam int unsigned OUT_SPEED_W = 17;
  localparam int unsigned POS_W      = 4;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned M_TDATA_W  = 40;

  // bytes of each sub-frame that the crc covers
  localparam logic [2:0] SUBFRAME_DATA_BYTES = 3'd6;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [7:0] HDR_FUNC = 8'h42;
  localparam logic [7:0] HDR_ZERO = 8'h00;
  localparam logic [7:0] HDR_LEN  = 8'h04;

  localparam logic [7:0]  RST_LEFT_ID   = 8'h01;
  localparam logic [7:0]  RST_RIGHT_ID  = 8'h02;
  localparam logic [15:0] RST_THRESHOLD = 16'd3600;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_ID   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_ID  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd2;

  // frame positions with a special meaning
  localparam logic [POS_W-1:0] POS_LEFT_ID    = 4'd0;
  localparam logic [POS_W-1:0] POS_LEFT_FUNC  = 4'd1;
  localparam logic [POS_W-1:0] POS_LEFT_ZERO  = 4'd2;
  localparam logic [POS_W-1:0] POS_LEFT_LEN   = 4'd3;
  localparam logic [POS_W-1:0] POS_LEFT_SPDH  = 4'd4;
  localparam logic [POS_W-1:0] POS_LEFT_SPDL  = 4'd5;
  localparam logic [POS_W-1:0] POS_LEFT_CRCL  = 4'd6;
  localparam logic [POS_W-1:0] POS_LEFT_CRCH  = 4'd7;
  localparam logic [POS_W-1:0] POS_RIGHT_ID   = 4'd8;
  localparam logic [POS_W-1:0] POS_RIGHT_FUNC = 4'd9;
  localparam logic [POS_W-1:0] POS_RIGHT_ZERO = 4'd10;
  localparam logic [POS_W-1:0] POS_RIGHT_LEN  = 4'd11;
  localparam logic [POS_W-1:0] POS_RIGHT_SPDH = 4'd12;
  localparam logic [POS_W-1:0] POS_RIGHT_SPDL = 4'd13;
  localparam logic [POS_W-1:0] POS_RIGHT_CRCL = 4'd14;
  localparam logic [POS_W-1:0] POS_RIGHT_CRCH = 4'd15;

  // modbus crc-16, reflected, one byte
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/dual_motor_reply_frame_parser.sv =====
// ----------------------------------------------------------------------------
// dual_motor_reply_frame_parser
// receives 16-byte dual wheel replies, checks headers and crc per sub-frame,
// and reports both wheel speeds as signed values
// ----------------------------------------------------------------------------
//
//  channel   dir  tdata (lsb first)                                   tuser/tlast
//  s_*       in   rx_byte[7:0]                                        -
//  m_*       out  left_speed[16:0] right_speed[16:0] left_crc_ok      -
//                 right_crc_ok, 4 zero pad bits
//  cfg_*     in   index 0 left unit id, 1 right unit id, 2 threshold  -
//
// one byte per cycle sustained while results are taken: a byte goes into the input
// register, from there it runs through the header check and one crc byte step and
// updates the frame state; on the last byte of a frame the result register is loaded
// reset clears position, crc, stored speeds and both valid flags, and loads the register defaults
// a held result stalls the input register only; one more byte is still taken
//
module dual_motor_reply_frame_parser
  import dmrfp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [BYTE_W-1:0]     s_tdata,    // rx_byte[7:0]
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [M_TDATA_W-1:0]  m_tdata,    // left_speed[16:0], right_speed[33:17],
                                            // left_crc_ok[34], right_crc_ok[35], zero pad
  input  logic                  cfg_wen,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // configuration
  logic [7:0]  left_id;
  logic [7:0]  right_id;
  logic [15:0] threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      left_id   <= RST_LEFT_ID;
      right_id  <= RST_RIGHT_ID;
      threshold <= RST_THRESHOLD;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        REG_LEFT_ID:   left_id   <= cfg_wdata[7:0];
        REG_RIGHT_ID:  right_id  <= cfg_wdata[7:0];
        REG_THRESHOLD: threshold <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input register
  logic              in_valid;
  logic [BYTE_W-1:0] in_byte;
  logic              advance;

  // input stage moves on when the result slot is free or being emptied
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
    end
  end

  // frame state
  logic [POS_W-1:0] pos;
  logic [15:0]      crc;
  logic             left_match;
  logic [7:0]       left_spd_hi, left_spd_lo, left_crc_lo;
  logic [7:0]       right_spd_hi, right_spd_lo, right_crc_lo;
  logic [15:0]      left_raw, right_raw;

  // header check for a given position
  function automatic logic hdr_ok(input logic [POS_W-1:0] p, input logic [7:0] b,
                                  input logic [7:0] lid, input logic [7:0] rid);
    logic ok;
    unique case (p)
      POS_LEFT_ID:                   ok = (b == lid);
      POS_RIGHT_ID:                  ok = (b == rid);
      POS_LEFT_FUNC, POS_RIGHT_FUNC: ok = (b == HDR_FUNC);
      POS_LEFT_ZERO, POS_RIGHT_ZERO: ok = (b == HDR_ZERO);
      POS_LEFT_LEN, POS_RIGHT_LEN:   ok = (b == HDR_LEN);
      default:                       ok = 1'b1;
    endcase
    return ok;
  endfunction

  logic             hdr_here;
  logic             drop;
  logic [POS_W-1:0] eff_pos;
  logic [2:0]       sub;
  logic [15:0]      crc_base;
  logic [15:0]      crc_next;
  logic             crc_match;
  logic             frame_done;
  logic             right_match;
  logic [15:0]      left_raw_next, right_raw_next;
  logic [OUT_SPEED_W-1:0] left_speed, right_speed, right_fwd;

  always_comb begin
    hdr_here = hdr_ok(pos, in_byte, left_id, right_id);
    // a bad header byte gets a second chance as the start of a new frame
    eff_pos  = hdr_here ? pos : POS_LEFT_ID;
    drop     = !hdr_here && (in_byte != left_id);
    sub      = eff_pos[2:0];
    crc_base = (sub == 3'd0) ? CRC_INIT : crc;
    crc_next = (sub < SUBFRAME_DATA_BYTES) ? crc16_byte(crc_base, in_byte) : crc_base;
    // crc high byte is the current one, low byte was stored one byte earlier
    crc_match = (in_byte == crc_next[15:8]) &&
                (((eff_pos == POS_LEFT_CRCH) ? left_crc_lo : right_crc_lo) == crc_next[7:0]);
    frame_done  = !drop && (eff_pos == POS_RIGHT_CRCH);
    right_match = crc_match;

    left_raw_next  = left_match  ? {left_spd_hi, left_spd_lo}   : left_raw;
    right_raw_next = right_match ? {right_spd_hi, right_spd_lo} : right_raw;

    // above threshold the raw value wraps negative
    left_speed  = {1'b0, left_raw_next} -
                  ((left_raw_next > threshold) ? 17'h10000 : 17'h00000);
    right_fwd   = {1'b0, right_raw_next} -
                  ((right_raw_next > threshold) ? 17'h10000 : 17'h00000);
    right_speed = 17'h00000 - right_fwd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos        <= POS_LEFT_ID;
      crc        <= CRC_INIT;
      left_match <= 1'b0;
      left_raw   <= 16'h0000;
      right_raw  <= 16'h0000;
    end else if (advance) begin
      if (drop) begin
        pos <= POS_LEFT_ID;
      end else begin
        crc <= crc_next;
        if (frame_done) begin
          pos        <= POS_LEFT_ID;
          left_match <= 1'b0;
          left_raw   <= left_raw_next;
          right_raw  <= right_raw_next;
        end else begin
          pos <= eff_pos + 4'd1;
          if (eff_pos == POS_LEFT_CRCH) begin
            left_match <= crc_match;
          end
        end
      end
    end
  end

  // captured payload bytes of the frame
  always_ff @(posedge clk) begin
    if (advance && !drop) begin
      unique case (eff_pos)
        POS_LEFT_SPDH:  left_spd_hi  <= in_byte;
        POS_LEFT_SPDL:  left_spd_lo  <= in_byte;
        POS_LEFT_CRCL:  left_crc_lo  <= in_byte;
        POS_RIGHT_SPDH: right_spd_hi <= in_byte;
        POS_RIGHT_SPDL: right_spd_lo <= in_byte;
        POS_RIGHT_CRCL: right_crc_lo <= in_byte;
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance && frame_done) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && frame_done) begin
      m_tdata <= {4'b0000, right_match, left_match, right_speed, left_speed};
    end
  end

endmodule

// ===== hw/rtl/dmrfp_checker.sv =====
// ----------------------------------------------------------------------------
// dmrfp_checker
// port-level checks for the dual motor reply parser
// ----------------------------------------------------------------------------
module dmrfp_checker
  import dmrfp_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 s_tvalid,
  input logic                 s_tready,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [M_TDATA_W-1:0] m_tdata
);

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // held result keeps its value
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("result changed while stalled");

  // with an empty result slot the input side never stalls
  a_no_false_stall: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty result slot");

  // only one byte is taken behind a stalled result
  a_one_deep: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready && s_tvalid && s_tready) |=> (m_tready || !s_tready))
    else $error("more than one byte taken behind a stalled result");

  // padding bits stay zero
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[M_TDATA_W-1:36] == 4'b0000))
    else $error("nonzero pad bits in result");

endmodule

bind dual_motor_reply_frame_parser dmrfp_checker u_dmrfp_checker (.*);

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for dual_motor_reply_frame_parser: a queue-fed stream
// driver, a predictor of the frame parser updated on each accepted byte, and a
// monitor that compares every speed report against the predicted one
// ----------------------------------------------------------------------------
module tb;
  import dmrfp_pkg::*;

  // wheel report as the predictor sees it
  typedef struct packed {
    logic [OUT_SPEED_W-1:0] left_speed;
    logic [OUT_SPEED_W-1:0] right_speed;
    logic                   left_ok;
    logic                   right_ok;
  } wheel_report_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [BYTE_W-1:0]     s_tdata = '0;      // rx_byte[7:0]
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_tdata;           // left_speed[16:0], right_speed[33:17],
                                            // left_crc_ok[34], right_crc_ok[35], zero pad
  logic                  cfg_wen = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  dual_motor_reply_frame_parser dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // predictor state: register copies and the frame parser's own state
  // --------------------------------------------------------------------------
  logic [7:0]  left_id_cfg   = RST_LEFT_ID;
  logic [7:0]  right_id_cfg  = RST_RIGHT_ID;
  logic [15:0] threshold_cfg = RST_THRESHOLD;

  logic [3:0]  frame_pos   = '0;
  logic [15:0] crc_acc     = 16'hFFFF;
  logic [7:0]  frame_bytes [16];
  logic [15:0] left_raw    = '0;
  logic [15:0] right_raw   = '0;
  logic        left_crc_latched = 1'b0;

  wheel_report_t report_expect[$];   // predicted reports, oldest first
  logic [7:0]    rx_stream[$];       // bytes waiting for the driver
  logic [7:0]    build_buf[$];       // frame under construction

  int unsigned errors = 0;
  int unsigned bytes_queued = 0;
  int unsigned bytes_taken = 0;
  int unsigned reports_checked = 0;
  int unsigned settings_used = 1;
  bit          gaps_on = 1'b1;
  int unsigned hold_req = 0;

  // modbus crc-16 step over one byte, reflected poly 0xA001
  function automatic logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
    logic [15:0] r;
    r = c ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ 16'hA001) : (r >> 1);
    end
    return r;
  endfunction

  // header bytes are fixed per position; speed and crc bytes pass unchecked
  function automatic bit header_fits(logic [3:0] p, logic [7:0] b);
    case (p)
      POS_LEFT_ID:                    return b == left_id_cfg;
      POS_RIGHT_ID:                   return b == right_id_cfg;
      POS_LEFT_FUNC, POS_RIGHT_FUNC:  return b == HDR_FUNC;
      POS_LEFT_ZERO, POS_RIGHT_ZERO:  return b == HDR_ZERO;
      POS_LEFT_LEN, POS_RIGHT_LEN:    return b == HDR_LEN;
      default:                        return 1'b1;
    endcase
  endfunction

  // raw speed above the threshold wraps negative; the right wheel is mirrored
  function automatic logic [OUT_SPEED_W-1:0] wheel_speed(logic [15:0] raw, bit mirror);
    int v;
    v = int'(raw);
    if (raw > threshold_cfg) v = v - 65536;
    if (mirror) v = -v;
    return v[OUT_SPEED_W-1:0];
  endfunction

  // advance the parser by one accepted byte, queue a report on frame end
  function automatic void absorb_byte(logic [7:0] b);
    logic [3:0]    p;
    bit            right_good;
    wheel_report_t r;
    p = frame_pos;
    if (!header_fits(p, b)) begin
      // drop the partial frame and try the byte as a fresh frame start
      p = POS_LEFT_ID;
      if (!header_fits(p, b)) begin
        frame_pos = POS_LEFT_ID;
        return;
      end
    end
    frame_bytes[p] = b;
    if (p[2:0] == 3'd0) crc_acc = 16'hFFFF;
    if (p[2:0] < SUBFRAME_DATA_BYTES) crc_acc = crc_step(crc_acc, b);
    if (p == POS_LEFT_CRCH) begin
      left_crc_latched = (frame_bytes[POS_LEFT_CRCL] == crc_acc[7:0]) && (b == crc_acc[15:8]);
    end
    if (p == POS_RIGHT_CRCH) begin
      right_good = (frame_bytes[POS_RIGHT_CRCL] == crc_acc[7:0]) && (b == crc_acc[15:8]);
      if (left_crc_latched)
        left_raw = {frame_bytes[POS_LEFT_SPDH], frame_bytes[POS_LEFT_SPDL]};
      if (right_good)
        right_raw = {frame_bytes[POS_RIGHT_SPDH], frame_bytes[POS_RIGHT_SPDL]};
      r.left_speed  = wheel_speed(left_raw, 1'b0);
      r.right_speed = wheel_speed(right_raw, 1'b1);
      r.left_ok     = left_crc_latched;
      r.right_ok    = right_good;
      report_expect.push_back(r);
      frame_pos = POS_LEFT_ID;
      left_crc_latched = 1'b0;
      return;
    end
    frame_pos = p + 4'd1;
  endfunction

  task automatic flag_error(input string msg);
    errors++;
    if (errors <= 40) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // --------------------------------------------------------------------------
  // byte driver: offers queued bytes, random gaps while gaps_on is set
  // --------------------------------------------------------------------------
  int unsigned tx_gap = 0;

  always @(posedge clk) begin : byte_driver
    logic       next_valid;
    logic [7:0] next_byte;
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
    end else begin
      next_valid = s_tvalid;
      next_byte  = s_tdata;
      if (s_tvalid && s_tready) begin
        absorb_byte(s_tdata);
        bytes_taken++;
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (tx_gap != 0) begin
          tx_gap--;
        end else if (rx_stream.size() != 0) begin
          if (gaps_on && $urandom_range(0, 5) == 0) begin
            // random idle burst before the next byte is offered
            tx_gap = $urandom_range(0, 3);
          end else begin
            next_valid = 1'b1;
            next_byte  = rx_stream.pop_front();
          end
        end
      end
      s_tvalid <= next_valid;
      s_tdata  <= next_byte;
    end
  end

  // --------------------------------------------------------------------------
  // report sink: random stall bursts plus one long hold-off on request
  // --------------------------------------------------------------------------
  int unsigned rx_gap = 0;
  int unsigned hold_left = 0;
  int unsigned hold_seen = 0;

  always @(posedge clk) begin : report_ready
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = 100;
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (rx_gap != 0) begin
      rx_gap--;
      m_tready <= 1'b0;
    end else if (gaps_on && $urandom_range(0, 4) == 0) begin
      rx_gap = $urandom_range(0, 3);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // every accepted report against the oldest prediction
  always @(posedge clk) begin : report_check
    wheel_report_t want;
    logic [OUT_SPEED_W-1:0] got_left;
    logic [OUT_SPEED_W-1:0] got_right;
    if (!rst && m_tvalid && m_tready) begin
      got_left  = m_tdata[16:0];
      got_right = m_tdata[33:17];
      if (report_expect.size() == 0) begin
        flag_error($sformatf("report with none pending, tdata %h", m_tdata));
      end else begin
        want = report_expect.pop_front();
        reports_checked++;
        if (got_left != want.left_speed)
          flag_error($sformatf("left_speed %0d, predicted %0d",
                               $signed(got_left), $signed(want.left_speed)));
        if (got_right != want.right_speed)
          flag_error($sformatf("right_speed %0d, predicted %0d",
                               $signed(got_right), $signed(want.right_speed)));
        if (m_tdata[34] != want.left_ok)
          flag_error($sformatf("left_crc_ok %0b, predicted %0b", m_tdata[34], want.left_ok));
        if (m_tdata[35] != want.right_ok)
          flag_error($sformatf("right_crc_ok %0b, predicted %0b", m_tdata[35], want.right_ok));
      end
    end
  end

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  // one sub-frame into the build buffer, crc optionally spoiled by a bit flip
  function automatic void put_subframe(logic [7:0] id, logic [15:0] spd, bit bad_crc);
    logic [15:0] c;
    c = crc_step(16'hFFFF, id);
    c = crc_step(c, HDR_FUNC);
    c = crc_step(c, HDR_ZERO);
    c = crc_step(c, HDR_LEN);
    c = crc_step(c, spd[15:8]);
    c = crc_step(c, spd[7:0]);
    if (bad_crc) c = c ^ (16'h0001 << $urandom_range(0, 15));
    build_buf.push_back(id);
    build_buf.push_back(HDR_FUNC);
    build_buf.push_back(HDR_ZERO);
    build_buf.push_back(HDR_LEN);
    build_buf.push_back(spd[15:8]);
    build_buf.push_back(spd[7:0]);
    build_buf.push_back(c[7:0]);
    build_buf.push_back(c[15:8]);
  endfunction

  function automatic void flush_build();
    foreach (build_buf[i]) rx_stream.push_back(build_buf[i]);
    bytes_queued += build_buf.size();
    build_buf.delete();
  endfunction

  function automatic void send_frame(logic [15:0] ls, logic [15:0] rs, bit bad_l, bit bad_r);
    put_subframe(left_id_cfg, ls, bad_l);
    put_subframe(right_id_cfg, rs, bad_r);
    flush_build();
  endfunction

  function automatic void send_bytes(logic [7:0] b);
    rx_stream.push_back(b);
    bytes_queued++;
  endfunction

  // speeds cluster around the threshold and the ends of the range
  function automatic logic [15:0] pick_speed();
    case ($urandom_range(0, 5))
      0:       return threshold_cfg;
      1:       return threshold_cfg + 16'd1;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // mostly well-formed frames, some broken ones and some line noise
  task automatic random_traffic(input int unsigned n_bytes);
    int unsigned start;
    int unsigned kind;
    int unsigned hp;
    int unsigned keep;
    start = bytes_queued;
    while (bytes_queued - start < n_bytes) begin
      kind = $urandom_range(0, 19);
      if (kind < 14) begin
        send_frame(pick_speed(), pick_speed(),
                   $urandom_range(0, 5) == 0, $urandom_range(0, 5) == 0);
      end else if (kind < 17) begin
        put_subframe(left_id_cfg, pick_speed(), 1'b0);
        put_subframe(right_id_cfg, pick_speed(), 1'b0);
        if ($urandom_range(0, 1) == 1) begin
          // spoil one header byte of either sub-frame
          hp = $urandom_range(0, 3) + ($urandom_range(0, 1) == 1 ? 8 : 0);
          build_buf[hp] = build_buf[hp] ^ 8'($urandom_range(1, 255));
        end else begin
          // cut the frame short
          keep = $urandom_range(1, 15);
          while (build_buf.size() > keep) void'(build_buf.pop_back());
        end
        flush_build();
      end else begin
        repeat ($urandom_range(1, 6)) begin
          send_bytes($urandom_range(0, 3) == 0 ? left_id_cfg : 8'($urandom_range(0, 255)));
        end
      end
      while (rx_stream.size() > 32) @(posedge clk);
    end
  endtask

  // wait until every byte is taken and every report has come back
  task automatic settle();
    while (bytes_taken != bytes_queued || report_expect.size() != 0) @(posedge clk);
    // trailing bytes of a partial frame may still be in the pipeline
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_LEFT_ID:   left_id_cfg   = val[7:0];
      REG_RIGHT_ID:  right_id_cfg  = val[7:0];
      REG_THRESHOLD: threshold_cfg = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_wen <= 1'b0;
  endtask

  task automatic set_config(input logic [7:0] lid, input logic [7:0] rid, input logic [15:0] thr);
    write_reg(REG_LEFT_ID, {8'h00, lid});
    write_reg(REG_RIGHT_ID, {8'h00, rid});
    write_reg(REG_THRESHOLD, thr);
    settings_used++;
  endtask

  // --------------------------------------------------------------------------
  // test sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed, reset register values
    send_frame(16'h0000, 16'h0000, 1'b0, 1'b0);
    // stray byte, then a frame start cut off by a bad zero byte that is
    // itself the left unit id, so the next frame starts on it
    send_bytes(8'h55);
    send_bytes(RST_LEFT_ID);
    send_bytes(HDR_FUNC);
    send_frame(16'hFFFF, RST_THRESHOLD, 1'b0, 1'b0);
    // bad left crc keeps the old left speed, right raw speed 16'hFFFF wraps negative
    send_frame(RST_THRESHOLD + 16'd1, 16'hFFFF, 1'b1, 1'b0);
    settle();

    set_config(8'h00, 8'hFF, 16'h0000);
    send_frame(16'h0000, 16'h0001, 1'b0, 1'b1);
    random_traffic(80);
    settle();

    // threshold at maximum: every raw speed counts as forward
    set_config(8'hFF, 8'h00, 16'hFFFF);
    hold_req++;
    repeat (6) send_frame(pick_speed(), pick_speed(), 1'b0, 1'b0);
    random_traffic(70);
    settle();

    set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
               16'($urandom_range(0, 65535)));
    random_traffic(80);
    settle();

    set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
               16'($urandom_range(0, 8000)));
    random_traffic(60);
    settle();

    // closing stretch without idling on either side
    gaps_on = 1'b0;
    set_config(RST_LEFT_ID, RST_RIGHT_ID, RST_THRESHOLD);
    random_traffic(50);
    settle();

    $display("covered %0d bytes over %0d register settings, %0d speed reports checked",
             bytes_taken, settings_used, reports_checked);
    $display("included resync on bad headers, truncated frames, bad crcs and one long stall");
    if (errors == 0) begin
      $display("dual_motor_reply_frame_parser regression: pass");
    end else begin
      $display("dual_motor_reply_frame_parser regression: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #2_400_000;
    $display("timeout with %0d reports outstanding", report_expect.size());
    $display("dual_motor_reply_frame_parser regression: fail");
    $finish;
  end

endmodule
